// ===== design/qts_pkg.sv =====
// ----------------------------------------------------------------------------
// qts_pkg: shared types and constants for the queued tone sequencer
// segment record layout, queue geometry, item kind codes, slot arithmetic
// ----------------------------------------------------------------------------
`default_nettype none

package qts_pkg;

  localparam int unsigned QUEUE_SLOTS = 16;
  localparam int unsigned SLOT_W      = $clog2(QUEUE_SLOTS);

  localparam int unsigned FREQ_W = 16;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned DUTY_W = 8;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic {
    KIND_TICK    = 1'b0,
    KIND_ENQUEUE = 1'b1
  } kind_e;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [LEN_W-1:0]  len;
    logic [DUTY_W-1:0] duty;
  } seg_t;

  // ring increment, wraps at the last slot
  function automatic slot_t next_slot(input slot_t s);
    slot_t r;
    if (s == slot_t'(QUEUE_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = s + slot_t'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/queued_tone_sequencer.sv =====
// ----------------------------------------------------------------------------
// queued_tone_sequencer: buzzer tone sequencer fed by a ring queue
// enqueue transactions store tone segments, tick transactions play them out
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_stall_o) carries one transaction per item:
//   kind 1 enqueues a segment (frequency, duration, duty), kind 0 is a
//   one millisecond tick that advances the playing segment.
//   output channel (out_valid_o / out_stall_i) returns exactly one result per
//   input transaction: accepted flag, current drive frequency and duty, and
//   the playing flag, all as they stand after that transaction.
//   the result of a transaction is registered and shows in the cycle after
//   it is taken. throughput is one transaction per cycle while the receiver
//   does not stall, set by the single output register that holds the result.
//   when the receiver stalls, the result stays in the output register and
//   the input is stalled only while that register is full and stalled, so
//   a result being taken in the same cycle frees room for the next item.
//   reset clears the queue pointers, the active segment and the output valid;
//   the segment store itself is not cleared (only written slots are read).
// ----------------------------------------------------------------------------
`default_nettype none

module queued_tone_sequencer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [15:0] tone_frequency_i,
  input  wire logic [15:0] duration_ms_i,
  input  wire logic [7:0]  tone_duty_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             accepted_o,
  output logic [15:0]      drive_frequency_o,
  output logic [7:0]       drive_duty_o,
  output logic             playing_o
);

  // segment store, written at the write slot, read at the read slot only
  qts_pkg::seg_t store_q [qts_pkg::QUEUE_SLOTS];

  qts_pkg::slot_t rd_q, rd_d;
  qts_pkg::slot_t wr_q, wr_d;
  logic           active_q, active_d;
  logic [15:0]    freq_q, freq_d;
  logic [7:0]     duty_q, duty_d;
  logic [15:0]    len_q, len_d;
  logic [15:0]    elapsed_q, elapsed_d;

  logic           out_valid_q;
  logic           accepted_q, accepted_d;
  logic [15:0]    drv_freq_q, drv_freq_d;
  logic [7:0]     drv_duty_q, drv_duty_d;
  logic           playing_q;

  logic           take;
  logic           store_we;
  qts_pkg::seg_t  wr_seg;
  qts_pkg::seg_t  rd_seg;
  qts_pkg::slot_t wr_next;
  logic           queue_full;
  logic           queue_empty;
  logic [15:0]    elapsed_inc;
  logic           still_active;
  logic           sound;

  // input is held off only while a finished result waits and is stalled
  assign in_stall_o = out_valid_q & out_stall_i;
  assign take       = in_valid_i & ~in_stall_o;

  assign wr_next     = qts_pkg::next_slot(wr_q);
  assign queue_full  = (wr_next == rd_q);
  assign queue_empty = (rd_q == wr_q);
  assign rd_seg      = store_q[rd_q];

  assign wr_seg.freq = tone_frequency_i;
  assign wr_seg.len  = duration_ms_i;
  assign wr_seg.duty = tone_duty_i;

  // saturating millisecond count of the playing segment
  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;

  always_comb begin
    rd_d         = rd_q;
    wr_d         = wr_q;
    active_d     = active_q;
    freq_d       = freq_q;
    duty_d       = duty_q;
    len_d        = len_q;
    elapsed_d    = elapsed_q;
    accepted_d   = 1'b0;
    store_we     = 1'b0;
    still_active = active_q;

    unique case (qts_pkg::kind_e'(kind_i))
      qts_pkg::KIND_ENQUEUE: begin
        // one slot stays empty, so a full ring rejects the segment
        if (!queue_full) begin
          store_we   = take;
          wr_d       = wr_next;
          accepted_d = 1'b1;
        end
      end
      qts_pkg::KIND_TICK: begin
        if (active_q) begin
          elapsed_d    = elapsed_inc;
          still_active = (elapsed_inc < len_q);
        end
        active_d = still_active;
        // idle after this tick: pull the next segment if one is waiting
        if (!still_active && !queue_empty) begin
          freq_d    = rd_seg.freq;
          len_d     = rd_seg.len;
          duty_d    = rd_seg.duty;
          elapsed_d = '0;
          active_d  = 1'b1;
          rd_d      = qts_pkg::next_slot(rd_q);
        end
      end
      default: begin
      end
    endcase

    // silent when nothing plays or the segment has zero frequency or duty
    sound      = active_d && (freq_d != '0) && (duty_d != '0);
    drv_freq_d = sound ? freq_d : '0;
    drv_duty_d = sound ? duty_d : '0;
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[wr_q] <= wr_seg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q      <= '0;
      wr_q      <= '0;
      active_q  <= 1'b0;
      freq_q    <= '0;
      duty_q    <= '0;
      len_q     <= '0;
      elapsed_q <= '0;
    end else if (take) begin
      rd_q      <= rd_d;
      wr_q      <= wr_d;
      active_q  <= active_d;
      freq_q    <= freq_d;
      duty_q    <= duty_d;
      len_q     <= len_d;
      elapsed_q <= elapsed_d;
    end
  end

  // output register valid: loads on every input transaction, drains when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (take) begin
      accepted_q <= accepted_d;
      drv_freq_q <= drv_freq_d;
      drv_duty_q <= drv_duty_d;
      playing_q  <= active_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = accepted_q;
  assign drive_frequency_o = drv_freq_q;
  assign drive_duty_o      = drv_duty_q;
  assign playing_o         = playing_q;

`ifndef SYNTH
  // a tick transaction never reports a stored segment
  a_tick_not_accepted: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (take && kind_i == qts_pkg::KIND_TICK) |=> !accepted_o
  ) else $error("tick transaction reported as accepted");

  // the drive is silent whenever no segment plays
  a_silent_when_idle: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !playing_o) |-> (drive_frequency_o == '0 && drive_duty_o == '0)
  ) else $error("drive active while not playing");

  // an enqueue against a full ring leaves the write slot alone
  a_full_rejects: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (take && kind_i == qts_pkg::KIND_ENQUEUE && queue_full) |=> ($stable(wr_q) && !accepted_o)
  ) else $error("full queue accepted a segment");

  // a stalled result is held until the receiver takes it
  a_stalled_result_holds: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(playing_o) && $stable(accepted_o))
  ) else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
